[rtl/hrr_pkg.sv]
// Shared types, codes and search helpers for the health-checked round-robin core.
// No dependencies; used by rtl/health_checked_round_robin_core.sv.

package hrr_pkg;

  localparam int unsigned MAX_SERVERS = 16;
  localparam int unsigned SRV_W       = 4;   // server index width
  localparam int unsigned POOL_W      = 5;   // pool size, 1..16
  localparam int unsigned MISS_W      = 8;
  localparam int unsigned CID_W       = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // command codes (in_tuser)
  localparam logic [1:0] CMD_CONNECT  = 2'd0;
  localparam logic [1:0] CMD_REPLY    = 2'd1;
  localparam logic [1:0] CMD_INTERVAL = 2'd2;

  // result kinds (out_tuser)
  localparam logic [1:0] KIND_ASSIGN   = 2'd0;
  localparam logic [1:0] KIND_FAILOVER = 2'd1;
  localparam logic [1:0] KIND_DOWN     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONN,
    ST_RD,
    ST_MOD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             found;
    logic [SRV_W-1:0] idx;
  } pick_t;

  // register value 0 acts as 1, anything above the pool capacity is clipped
  function automatic logic [POOL_W-1:0] pool_size(input logic [POOL_W-1:0] a);
    logic [POOL_W-1:0] n;
    n = a;
    if (n == '0) n = POOL_W'(1);
    else if (n > POOL_W'(MAX_SERVERS)) n = POOL_W'(MAX_SERVERS);
    return n;
  endfunction

  function automatic logic [MAX_SERVERS-1:0] pool_mask(input logic [POOL_W-1:0] n);
    logic [MAX_SERVERS-1:0] m;
    for (int k = 0; k < MAX_SERVERS; k++) begin
      m[k] = (POOL_W'(k) < n);
    end
    return m;
  endfunction

  // first set bit at or above start, else first set bit from 0
  function automatic pick_t next_live(input logic [MAX_SERVERS-1:0] live,
                                      input logic [SRV_W-1:0]       start);
    logic [MAX_SERVERS-1:0] hi;
    pick_t r;
    hi = live;
    r  = '0;
    for (int k = 0; k < MAX_SERVERS; k++) begin
      if (SRV_W'(k) < start) hi[k] = 1'b0;
    end
    for (int k = MAX_SERVERS - 1; k >= 0; k--) begin
      if (live[k]) begin
        r.found = 1'b1;
        r.idx   = SRV_W'(k);
      end
    end
    for (int k = MAX_SERVERS - 1; k >= 0; k--) begin
      if (hi[k]) begin
        r.idx = SRV_W'(k);
      end
    end
    return r;
  endfunction

endpackage

[rtl/health_checked_round_robin_core.sv]
// Health-checked round-robin server picker: pick sequencer, miss-count memory, result register.
// Depends on rtl/hrr_pkg.sv.
//
// Sequencing: a connect passes through ST_CONN to the result register once it is free; a
// heartbeat reply is taken in ST_IDLE and gives no result; an interval end walks the pool with
// a registered read of the miss-count memory (ST_RD) and an update (ST_MOD) for each server,
// then ST_FIN, and waits while the result side stalls. One item is worked on at a time.
// Reset (rst_n, synchronous, active low): miss counts read as zero, nothing blacklisted or
// answered, first pick is server 0, client ids restart at 1, monitoring runs; no clearing pass.

module health_checked_round_robin_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] reply_server, [7:5] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] server_index, [7:4] failover_index, [39:8] client_id
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  localparam int unsigned NS = hrr_pkg::MAX_SERVERS;
  localparam int unsigned SW = hrr_pkg::SRV_W;
  localparam int unsigned PW = hrr_pkg::POOL_W;
  localparam int unsigned MW = hrr_pkg::MISS_W;
  localparam int unsigned CW = hrr_pkg::CID_W;

  // control state
  hrr_pkg::state_t state_r, state_nxt;
  logic [NS-1:0]   bl_r, bl_nxt;       // blacklisted
  logic [NS-1:0]   ans_r, ans_nxt;     // answered this interval
  logic [NS-1:0]   mvld_r, mvld_nxt;   // miss-count entry holds a written value
  logic [SW-1:0]   last_pick_r, last_pick_nxt;
  logic [CW-1:0]   cid_r, cid_nxt;
  logic            stop_r, stop_nxt;
  logic [PW-1:0]   act_r;
  logic [MW-1:0]   lim_r;
  logic [SW-1:0]   idx_r, idx_nxt;     // walk position, also memory read address

  // result held back until it is known whether it is the last of the walk
  logic            pend_v_r, pend_v_nxt;
  logic [1:0]      pend_kind_r, pend_kind_nxt;
  logic [SW-1:0]   pend_srv_r, pend_srv_nxt;
  logic [SW-1:0]   pend_fo_r, pend_fo_nxt;

  // result register
  logic            ov_r, ov_nxt;
  logic [1:0]      okind_r, okind_nxt;
  logic [SW-1:0]   osrv_r, osrv_nxt;
  logic [SW-1:0]   ofo_r, ofo_nxt;
  logic [CW-1:0]   ocid_r, ocid_nxt;
  logic            olast_r, olast_nxt;

  // miss-count memory
  logic [MW-1:0]   miss_mem [NS];
  logic [MW-1:0]   rd_q;
  logic            mem_we;
  logic [MW-1:0]   mem_wdata;

  // datapath
  logic [PW-1:0]   n;
  logic [NS-1:0]   pmask;
  logic            out_free;
  logic [MW-1:0]   cur_miss;
  logic [MW-1:0]   inc_miss;
  logic [NS-1:0]   bl_set;
  logic [SW-1:0]   fo_start;
  logic [SW-1:0]   conn_start;
  hrr_pkg::pick_t  fo_pick;
  hrr_pkg::pick_t  conn_pick;
  logic            idx_is_last;
  logic [PW-1:0]   rs;
  logic [SW-1:0]   rs_idx;

  assign n        = hrr_pkg::pool_size(act_r);
  assign pmask    = hrr_pkg::pool_mask(n);
  assign out_free = !ov_r || out_tready;
  assign rs       = in_tdata[PW-1:0];
  assign rs_idx   = SW'(rs - PW'(1));

  // miss count: unwritten entries read as zero, saturating increment
  assign cur_miss = mvld_r[idx_r] ? rd_q : '0;
  assign inc_miss = (cur_miss == {MW{1'b1}}) ? cur_miss : cur_miss + MW'(1);

  // failover search runs on the mask with the current server already blacklisted
  assign bl_set      = bl_r | (NS'(1) << idx_r);
  assign fo_start    = (({1'b0, idx_r} + PW'(1)) >= n) ? '0 : idx_r + SW'(1);
  assign fo_pick     = hrr_pkg::next_live(~bl_set & pmask, fo_start);
  // a stale last pick outside the pool restarts the search at 0
  assign conn_start  = (({1'b0, last_pick_r} + PW'(1)) >= n) ? '0 : last_pick_r + SW'(1);
  assign conn_pick   = hrr_pkg::next_live(~bl_r & pmask, conn_start);
  assign idx_is_last = ({1'b0, idx_r} == (n - PW'(1)));

  assign in_tready = (state_r == hrr_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    bl_nxt        = bl_r;
    ans_nxt       = ans_r;
    mvld_nxt      = mvld_r;
    last_pick_nxt = last_pick_r;
    cid_nxt       = cid_r;
    stop_nxt      = stop_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_srv_nxt  = pend_srv_r;
    pend_fo_nxt   = pend_fo_r;
    ov_nxt        = ov_r && !out_tready;
    okind_nxt     = okind_r;
    osrv_nxt      = osrv_r;
    ofo_nxt       = ofo_r;
    ocid_nxt      = ocid_r;
    olast_nxt     = olast_r;
    mem_we        = 1'b0;
    mem_wdata     = inc_miss;

    unique case (state_r)
      hrr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            hrr_pkg::CMD_CONNECT: begin
              state_nxt = hrr_pkg::ST_CONN;
            end
            hrr_pkg::CMD_REPLY: begin
              // clearing the valid bit makes the entry read as zero
              if (!stop_r && rs != '0 && rs <= n) begin
                mvld_nxt[rs_idx] = 1'b0;
                ans_nxt[rs_idx]  = 1'b1;
              end
            end
            hrr_pkg::CMD_INTERVAL: begin
              if (!stop_r) begin
                idx_nxt   = '0;
                state_nxt = hrr_pkg::ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      hrr_pkg::ST_CONN: begin
        if (out_free) begin
          cid_nxt   = cid_r + CW'(1);
          ov_nxt    = 1'b1;
          okind_nxt = conn_pick.found ? hrr_pkg::KIND_ASSIGN : hrr_pkg::KIND_DOWN;
          osrv_nxt  = conn_pick.found ? conn_pick.idx : '0;
          ofo_nxt   = '0;
          ocid_nxt  = cid_r + CW'(1);
          olast_nxt = 1'b1;
          if (conn_pick.found) last_pick_nxt = conn_pick.idx;
          state_nxt = hrr_pkg::ST_IDLE;
        end
      end

      hrr_pkg::ST_RD: begin
        // read of entry idx_r is under way
        state_nxt = hrr_pkg::ST_MOD;
      end

      hrr_pkg::ST_MOD: begin
        if (ans_r[idx_r] || bl_r[idx_r] || inc_miss < lim_r) begin
          if (!ans_r[idx_r] && !bl_r[idx_r]) begin
            mem_we          = 1'b1;
            mvld_nxt[idx_r] = 1'b1;
          end
          if (idx_is_last) begin
            state_nxt = hrr_pkg::ST_FIN;
          end else begin
            idx_nxt   = idx_r + SW'(1);
            state_nxt = hrr_pkg::ST_RD;
          end
        end else if (!pend_v_r || out_free) begin
          // limit reached: blacklist, push out the held result, hold the new one
          mem_we          = 1'b1;
          mvld_nxt[idx_r] = 1'b1;
          bl_nxt          = bl_set;
          if (pend_v_r) begin
            ov_nxt    = 1'b1;
            okind_nxt = pend_kind_r;
            osrv_nxt  = pend_srv_r;
            ofo_nxt   = pend_fo_r;
            ocid_nxt  = '0;
            olast_nxt = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_srv_nxt = idx_r;
          if (fo_pick.found) begin
            pend_kind_nxt = hrr_pkg::KIND_FAILOVER;
            pend_fo_nxt   = fo_pick.idx;
            if (idx_is_last) begin
              state_nxt = hrr_pkg::ST_FIN;
            end else begin
              idx_nxt   = idx_r + SW'(1);
              state_nxt = hrr_pkg::ST_RD;
            end
          end else begin
            // nothing live is left: monitoring stops, walk ends
            pend_kind_nxt = hrr_pkg::KIND_DOWN;
            pend_fo_nxt   = '0;
            stop_nxt      = 1'b1;
            state_nxt     = hrr_pkg::ST_FIN;
          end
        end
      end

      hrr_pkg::ST_FIN: begin
        ans_nxt = '0;
        if (!pend_v_r) begin
          state_nxt = hrr_pkg::ST_IDLE;
        end else if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = pend_kind_r;
          osrv_nxt   = pend_srv_r;
          ofo_nxt    = pend_fo_r;
          ocid_nxt   = '0;
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = hrr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hrr_pkg::ST_IDLE;
      end
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrr_pkg::ST_IDLE;
      bl_r        <= '0;
      ans_r       <= '0;
      mvld_r      <= '0;
      last_pick_r <= SW'(NS - 1);
      cid_r       <= '0;
      stop_r      <= 1'b0;
      act_r       <= PW'(16);
      lim_r       <= MW'(3);
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bl_r        <= bl_nxt;
      ans_r       <= ans_nxt;
      mvld_r      <= mvld_nxt;
      last_pick_r <= last_pick_nxt;
      cid_r       <= cid_nxt;
      stop_r      <= stop_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      ov_r        <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          hrr_pkg::REG_ACTIVE: act_r <= cfg_wdata[PW-1:0];
          hrr_pkg::REG_LIMIT:  lim_r <= cfg_wdata[MW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_srv_r  <= pend_srv_nxt;
    pend_fo_r   <= pend_fo_nxt;
    okind_r     <= okind_nxt;
    osrv_r      <= osrv_nxt;
    ofo_r       <= ofo_nxt;
    ocid_r      <= ocid_nxt;
    olast_r     <= olast_nxt;
  end

  // miss-count memory: one write, one registered read at the walk position
  always_ff @(posedge clk) begin
    if (mem_we) begin
      miss_mem[idx_r] <= mem_wdata;
    end
    rd_q <= miss_mem[idx_r];
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {ocid_r, ofo_r, osrv_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  // once monitoring stops it never restarts
  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("monitoring restarted after all servers went down");

  // an all-down result always closes its item
  a_down_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == hrr_pkg::KIND_DOWN) |-> out_tlast)
    else $error("all-down result not marked last");

  // a held result is always flushed before the sequencer goes idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hrr_pkg::ST_IDLE) |-> !pend_v_r)
    else $error("held result left behind at end of walk");

endmodule
